>>> sv/amcs_pkg.sv
// Shared types, codes and bit positions for the motion command sequencer.
package amcs_pkg;

   localparam int CMD_W  = 12;
   localparam int UNIT_W = 11;
   localparam int EXE_W  = 10;
   localparam int CODE_W = 16;
   localparam int STEP_W = 4;
   localparam int VSRC_W = 2;

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_IDX_HOME_ON_PU = 1'b0;

   typedef enum logic [4:0] {
      ST_WAIT  = 5'd0,
      ST_PON   = 5'd1,
      ST_HOME  = 5'd2,
      ST_READY = 5'd3,
      ST_HALT  = 5'd4,
      ST_STOP  = 5'd5,
      ST_JOGP  = 5'd6,
      ST_JOGN  = 5'd7,
      ST_ABS   = 5'd8,
      ST_ADD   = 5'd9,
      ST_VEL   = 5'd10,
      ST_GIN   = 5'd11,
      ST_GOUT  = 5'd12,
      ST_ERR   = 5'd13,
      ST_AXERR = 5'd14,
      ST_ERST  = 5'd15,
      ST_READ  = 5'd16
   } step_type;

   // command latch bits
   localparam logic [CMD_W-1:0] C_POWER = 12'h001;
   localparam logic [CMD_W-1:0] C_STOP  = 12'h002;
   localparam logic [CMD_W-1:0] C_HOME  = 12'h004;
   localparam logic [CMD_W-1:0] C_JOGP  = 12'h008;
   localparam logic [CMD_W-1:0] C_JOGN  = 12'h010;
   localparam logic [CMD_W-1:0] C_ABS   = 12'h020;
   localparam logic [CMD_W-1:0] C_ADD   = 12'h040;
   localparam logic [CMD_W-1:0] C_VEL   = 12'h080;
   localparam logic [CMD_W-1:0] C_GIN   = 12'h100;
   localparam logic [CMD_W-1:0] C_GOUT  = 12'h200;
   localparam logic [CMD_W-1:0] C_HALT  = 12'h400;
   localparam logic [CMD_W-1:0] C_ACK   = 12'h800;
   localparam logic [CMD_W-1:0] CMD_STOP_GROUP =
      C_STOP | C_HOME | C_JOGP | C_JOGN | C_VEL | C_ABS | C_ADD;

   // unit flag positions
   localparam logic [3:0] U_POWER = 4'd0;
   localparam logic [3:0] U_HOME  = 4'd1;
   localparam logic [3:0] U_HALT  = 4'd2;
   localparam logic [3:0] U_STOP  = 4'd3;
   localparam logic [3:0] U_VEL   = 4'd4;
   localparam logic [3:0] U_ABS   = 4'd5;
   localparam logic [3:0] U_ADD   = 4'd6;
   localparam logic [3:0] U_GIN   = 4'd7;
   localparam logic [3:0] U_GOUT  = 4'd8;
   localparam logic [3:0] U_RESET = 4'd9;
   localparam logic [3:0] U_READ  = 4'd10;

   // execute latch bits
   localparam logic [EXE_W-1:0] E_HOME  = 10'h001;
   localparam logic [EXE_W-1:0] E_HALT  = 10'h002;
   localparam logic [EXE_W-1:0] E_STOP  = 10'h004;
   localparam logic [EXE_W-1:0] E_VEL   = 10'h008;
   localparam logic [EXE_W-1:0] E_ABS   = 10'h010;
   localparam logic [EXE_W-1:0] E_ADD   = 10'h020;
   localparam logic [EXE_W-1:0] E_GIN   = 10'h040;
   localparam logic [EXE_W-1:0] E_GOUT  = 10'h080;
   localparam logic [EXE_W-1:0] E_RESET = 10'h100;
   localparam logic [EXE_W-1:0] E_READ  = 10'h200;
   localparam logic [EXE_W-1:0] EXE_STOP_GROUP =
      E_HOME | E_STOP | E_ABS | E_ADD | E_VEL | E_RESET;

   // velocity source codes
   localparam logic [VSRC_W-1:0] VSRC_PARAM = 2'd0;
   localparam logic [VSRC_W-1:0] VSRC_JOGP  = 2'd1;
   localparam logic [VSRC_W-1:0] VSRC_JOGN  = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd_set;
      logic [CMD_W-1:0]  cmd_clear;
      logic [UNIT_W-1:0] unit_done;
      logic [UNIT_W-1:0] unit_error;
      logic [CODE_W-1:0] active_error_code;
      logic [CODE_W-1:0] axis_error_code;
      logic              axis_error_valid;
      logic [CODE_W-1:0] axis_error_count;
      logic              error_stop;
      logic              synchronized_motion;
   } req_type;

   typedef struct packed {
      logic [STEP_W-1:0] step_code;
      logic [EXE_W-1:0]  unit_execute;
      logic              power_enable;
      logic [VSRC_W-1:0] velocity_source;
      logic              axis_error_ack;
      logic [CODE_W-1:0] error_code;
      logic [CMD_W-1:0]  command_latch;
   } rsp_type;

   typedef struct packed {
      step_type          step;
      logic [CMD_W-1:0]  commands;
      logic [EXE_W-1:0]  exe;
      logic              pwr;
      logic [VSRC_W-1:0] vsel;
      logic              ack;
      logic [CODE_W-1:0] err;
   } seq_state_type;

   typedef struct packed {
      logic                  psel;
      logic                  penable;
      logic                  pwrite;
      logic [CSR_ADDR_W-1:0] paddr;
      logic [CSR_DATA_W-1:0] pwdata;
   } apb_req_type;

endpackage

>>> sv/amcs_req_if.sv
// Input channel interface: one control tick per transaction.
interface amcs_req_if
   import amcs_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  cmd_set;
   logic [CMD_W-1:0]  cmd_clear;
   logic [UNIT_W-1:0] unit_done;
   logic [UNIT_W-1:0] unit_error;
   logic [CODE_W-1:0] active_error_code;
   logic [CODE_W-1:0] axis_error_code;
   logic              axis_error_valid;
   logic [CODE_W-1:0] axis_error_count;
   logic              error_stop;
   logic              synchronized_motion;

   modport source (
      output valid, cmd_set, cmd_clear, unit_done, unit_error, active_error_code,
             axis_error_code, axis_error_valid, axis_error_count, error_stop,
             synchronized_motion,
      input  ready
   );
   modport sink (
      input  valid, cmd_set, cmd_clear, unit_done, unit_error, active_error_code,
             axis_error_code, axis_error_valid, axis_error_count, error_stop,
             synchronized_motion,
      output ready
   );
endinterface

>>> sv/amcs_rsp_if.sv
// Result channel interface: sequencer outputs after one tick.
interface amcs_rsp_if
   import amcs_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [STEP_W-1:0] step_code;
   logic [EXE_W-1:0]  unit_execute;
   logic              power_enable;
   logic [VSRC_W-1:0] velocity_source;
   logic              axis_error_ack;
   logic [CODE_W-1:0] error_code;
   logic [CMD_W-1:0]  command_latch;

   modport source (
      output valid, step_code, unit_execute, power_enable, velocity_source,
             axis_error_ack, error_code, command_latch,
      input  ready
   );
   modport sink (
      input  valid, step_code, unit_execute, power_enable, velocity_source,
             axis_error_ack, error_code, command_latch,
      output ready
   );
endinterface

>>> sv/axis_motion_command_sequencer_unit.sv
// Top level of the single-axis motion command sequencer.
//
// One request transaction is one control tick: the command set/clear masks,
// the motion units' done and error flags and the axis error status. The block
// answers every request with exactly one response transaction carrying the
// new step, the execute and power latches, the velocity source, the axis
// error acknowledge, the latched error code and the command latch. The rate
// is one transaction per clock cycle while the response is not stalled; an
// accepted request is held in the input register, feeds the combinational
// step logic, and the result is loaded into the response register when free.
// While a response waits to be taken the input register can still hold one
// more request. The home-on-power-up bit is at CSR byte address 0 and should
// only be written while no tick is in flight.
module axis_motion_command_sequencer_unit
   import amcs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   amcs_req_if.sink              req_chan,
   amcs_rsp_if.source            rsp_chan,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   // ---- configuration ------------------------------------------------------
   apb_req_type apb;
   logic        home_on_pu;

   assign apb.psel    = csr_psel;
   assign apb.penable = csr_penable;
   assign apb.pwrite  = csr_pwrite;
   assign apb.paddr   = csr_paddr;
   assign apb.pwdata  = csr_pwdata;

   amcs_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .apb        (apb),
      .prdata     (csr_prdata),
      .pready     (csr_pready),
      .home_on_pu (home_on_pu)
   );

   // ---- input register -----------------------------------------------------
   logic    s1_valid_ff, s1_valid_in;
   req_type s1_ff, s1_in;
   logic    s1_adv;       // tick in stage one is processed this cycle
   logic    rsp_free;     // response register can take a new result

   assign rsp_free      = !rsp_chan.valid || rsp_chan.ready;
   assign s1_adv        = s1_valid_ff && rsp_free;
   assign req_chan.ready = !s1_valid_ff || rsp_free;

   always_comb begin
      s1_in.cmd_set             = req_chan.cmd_set;
      s1_in.cmd_clear           = req_chan.cmd_clear;
      s1_in.unit_done           = req_chan.unit_done;
      s1_in.unit_error          = req_chan.unit_error;
      s1_in.active_error_code   = req_chan.active_error_code;
      s1_in.axis_error_code     = req_chan.axis_error_code;
      s1_in.axis_error_valid    = req_chan.axis_error_valid;
      s1_in.axis_error_count    = req_chan.axis_error_count;
      s1_in.error_stop          = req_chan.error_stop;
      s1_in.synchronized_motion = req_chan.synchronized_motion;
      s1_valid_in = s1_valid_ff;
      if (req_chan.ready) begin
         s1_valid_in = req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   // payload: no reset needed
   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         s1_ff <= s1_in;
      end
   end

   // ---- sequencer state and step logic -------------------------------------
   seq_state_type state_ff, state_in, step_nxt;

   amcs_step u_step (
      .cur        (state_ff),
      .item       (s1_ff),
      .home_on_pu (home_on_pu),
      .nxt        (step_nxt)
   );

   // state only moves when a tick is handed on to the response register
   assign state_in = s1_adv ? step_nxt : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.step     <= ST_WAIT;
         state_ff.commands <= '0;
         state_ff.exe      <= '0;
         state_ff.pwr      <= 1'b0;
         state_ff.vsel     <= VSRC_PARAM;
         state_ff.ack      <= 1'b0;
         state_ff.err      <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

   // ---- response register --------------------------------------------------
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   always_comb begin
      // read state has code 16; the 4-bit field shows it as wait
      rsp_in.step_code       = step_nxt.step[STEP_W-1:0];
      rsp_in.unit_execute    = step_nxt.exe;
      rsp_in.power_enable    = step_nxt.pwr;
      rsp_in.velocity_source = step_nxt.vsel;
      rsp_in.axis_error_ack  = step_nxt.ack;
      rsp_in.error_code      = step_nxt.err;
      rsp_in.command_latch   = step_nxt.commands;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      if (s1_adv) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.step_code       = rsp_ff.step_code;
   assign rsp_chan.unit_execute    = rsp_ff.unit_execute;
   assign rsp_chan.power_enable    = rsp_ff.power_enable;
   assign rsp_chan.velocity_source = rsp_ff.velocity_source;
   assign rsp_chan.axis_error_ack  = rsp_ff.axis_error_ack;
   assign rsp_chan.error_code      = rsp_ff.error_code;
   assign rsp_chan.command_latch   = rsp_ff.command_latch;

   // ---- assertions ---------------------------------------------------------
   // a processed tick always shows up as a pending response
   a_adv_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      s1_adv |=> rsp_valid_ff)
      else $error("processed tick produced no response");

   // a stalled response freezes the sequencer state
   a_stall_holds_state: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_chan.ready) |=> $stable(state_ff))
      else $error("sequencer state moved while response stalled");

   // an empty input stage must always take a new transaction
   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> req_chan.ready)
      else $error("request refused with empty input stage");

endmodule

>>> sv/amcs_csr.sv
// APB-style register block holding the home-on-power-up control bit.
module amcs_csr
   import amcs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  apb_req_type           apb,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output logic                  home_on_pu
);

   logic home_on_pu_ff;
   logic home_on_pu_in;
   logic idx_hit;

   assign pready  = 1'b1;
   assign idx_hit = (apb.paddr[CSR_ADDR_W-1] == CSR_IDX_HOME_ON_PU);

   always_comb begin
      home_on_pu_in = home_on_pu_ff;
      if (apb.psel && apb.penable && apb.pwrite && idx_hit) begin
         home_on_pu_in = apb.pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         home_on_pu_ff <= 1'b0;
      end else begin
         home_on_pu_ff <= home_on_pu_in;
      end
   end

   assign prdata     = idx_hit ? {{(CSR_DATA_W-1){1'b0}}, home_on_pu_ff} : '0;
   assign home_on_pu = home_on_pu_ff;

endmodule

>>> sv/amcs_step.sv
// Next-state logic of the sequencer for one control tick.
module amcs_step
   import amcs_pkg::*;
(
   input  seq_state_type cur,
   input  req_type       item,
   input  logic          home_on_pu,
   output seq_state_type nxt
);

   logic [EXE_W-1:0] eb;
   logic [3:0]       ub;
   logic [CMD_W-1:0] held;

   always_comb begin
      nxt  = cur;
      eb   = E_ABS;
      ub   = U_ABS;
      held = C_JOGP;

      nxt.commands = (cur.commands & ~item.cmd_clear) | item.cmd_set;

      // central stop
      if ((nxt.commands & C_STOP) != '0 &&
          (nxt.step inside {[ST_READY:ST_GOUT], ST_AXERR})) begin
         nxt.exe      = nxt.exe & ~EXE_STOP_GROUP;
         nxt.ack      = 1'b0;
         nxt.commands = nxt.commands & ~CMD_STOP_GROUP;
         nxt.step     = ST_STOP;
      end

      // axis error and power-off overrides
      if (item.axis_error_code != '0 && item.axis_error_valid) begin
         nxt.step = ST_AXERR;
      end else if ((nxt.commands & C_POWER) == '0 && item.axis_error_valid) begin
         nxt.step = item.error_stop ? ST_ERST : ST_WAIT;
      end

      case (nxt.step)
         ST_WAIT: begin
            if ((nxt.commands & C_POWER) != '0) begin
               nxt.step = ST_PON;
            end else begin
               nxt.pwr = 1'b0;
            end
            nxt.exe      = nxt.exe & ~EXE_STOP_GROUP;
            nxt.ack      = 1'b0;
            nxt.commands = nxt.commands & ~CMD_STOP_GROUP;
            nxt.err      = '0;
         end
         ST_PON: begin
            nxt.pwr = 1'b1;
            if (item.unit_done[U_POWER]) begin
               if (home_on_pu) begin
                  nxt.commands = nxt.commands | C_HOME;
               end
               nxt.step = ST_READY;
            end
            if (item.unit_error[U_POWER]) begin
               nxt.err  = item.active_error_code;
               nxt.step = ST_ERR;
            end
         end
         ST_READY: begin
            // fixed priority dispatch; one-shot commands are consumed
            if ((nxt.commands & C_HOME) != '0) begin
               nxt.commands = nxt.commands & ~C_HOME;
               nxt.step     = ST_HOME;
            end else if ((nxt.commands & C_STOP) != '0) begin
               nxt.step = ST_STOP;
            end else if ((nxt.commands & C_JOGP) != '0) begin
               nxt.step = ST_JOGP;
            end else if ((nxt.commands & C_JOGN) != '0) begin
               nxt.step = ST_JOGN;
            end else if ((nxt.commands & C_ABS) != '0) begin
               nxt.commands = nxt.commands & ~C_ABS;
               nxt.step     = ST_ABS;
            end else if ((nxt.commands & C_ADD) != '0) begin
               nxt.commands = nxt.commands & ~C_ADD;
               nxt.step     = ST_ADD;
            end else if ((nxt.commands & C_VEL) != '0) begin
               nxt.commands = nxt.commands & ~C_VEL;
               nxt.step     = ST_VEL;
            end else if ((nxt.commands & C_GIN) != '0) begin
               nxt.commands = nxt.commands & ~C_GIN;
               nxt.step     = ST_GIN;
            end else if ((nxt.commands & C_GOUT) != '0) begin
               nxt.commands = nxt.commands & ~C_GOUT;
               nxt.step     = ST_GOUT;
            end else if ((nxt.commands & C_HALT) != '0) begin
               nxt.commands = nxt.commands & ~C_HALT;
               nxt.step     = ST_HALT;
            end
         end
         ST_HOME: begin
            if (!item.synchronized_motion) begin
               nxt.exe = nxt.exe | E_HOME;
               if (item.unit_done[U_HOME]) begin
                  nxt.exe  = nxt.exe & ~E_HOME;
                  nxt.step = ST_READ;
               end
               if (item.unit_error[U_HOME]) begin
                  nxt.err  = item.active_error_code;
                  nxt.exe  = nxt.exe & ~E_HOME;
                  nxt.step = ST_ERR;
               end
            end else begin
               // geared: ask for a gear-out first
               nxt.step     = ST_READ;
               nxt.commands = (nxt.commands & ~C_GIN) | C_GOUT;
            end
         end
         ST_HALT: begin
            nxt.exe = nxt.exe | E_HALT;
            if (item.unit_done[U_HALT]) begin
               nxt.exe  = nxt.exe & ~E_HALT;
               nxt.step = ST_READY;
            end
            if (item.unit_error[U_HALT]) begin
               nxt.err  = item.active_error_code;
               nxt.exe  = nxt.exe & ~E_HALT;
               nxt.step = ST_ERR;
            end
         end
         ST_STOP: begin
            nxt.exe = nxt.exe | E_STOP;
            if (item.unit_done[U_STOP] && (nxt.commands & C_STOP) == '0) begin
               nxt.exe  = nxt.exe & ~E_STOP;
               nxt.step = ST_READY;
            end
            if (item.unit_error[U_STOP]) begin
               nxt.err  = item.active_error_code;
               nxt.exe  = nxt.exe & ~E_STOP;
               nxt.step = ST_ERR;
            end
         end
         ST_JOGP, ST_JOGN: begin
            held     = (nxt.step == ST_JOGP) ? C_JOGP : C_JOGN;
            nxt.vsel = (nxt.step == ST_JOGP) ? VSRC_JOGP : VSRC_JOGN;
            nxt.exe  = nxt.exe | E_VEL;
            if ((nxt.commands & held) == '0) begin
               nxt.exe  = nxt.exe & ~E_VEL;
               nxt.step = ST_HALT;
            end
            if (item.unit_error[U_VEL]) begin
               nxt.err  = item.active_error_code;
               nxt.exe  = nxt.exe & ~E_VEL;
               nxt.step = ST_ERR;
            end
         end
         ST_ABS, ST_ADD, ST_VEL: begin
            if (nxt.step == ST_ADD) begin
               eb = E_ADD;
               ub = U_ADD;
            end else if (nxt.step == ST_VEL) begin
               eb       = E_VEL;
               ub       = U_VEL;
               nxt.vsel = VSRC_PARAM;
            end
            nxt.exe = nxt.exe | eb;
            if ((nxt.commands & C_HALT) != '0) begin
               nxt.commands = nxt.commands & ~C_HALT;
               nxt.exe      = nxt.exe & ~eb;
               nxt.step     = ST_HALT;
            end else if (item.unit_done[ub]) begin
               nxt.exe  = nxt.exe & ~eb;
               nxt.step = ST_READY;
            end
            if (item.unit_error[ub]) begin
               nxt.err  = item.active_error_code;
               nxt.exe  = nxt.exe & ~eb;
               nxt.step = ST_ERR;
            end
         end
         ST_GIN, ST_GOUT: begin
            eb      = (nxt.step == ST_GIN) ? E_GIN : E_GOUT;
            ub      = (nxt.step == ST_GIN) ? U_GIN : U_GOUT;
            nxt.exe = nxt.exe | eb;
            if (item.unit_done[ub]) begin
               nxt.exe  = nxt.exe & ~eb;
               nxt.step = ST_READY;
            end else if (item.unit_error[ub]) begin
               nxt.err  = item.active_error_code;
               nxt.exe  = nxt.exe & ~eb;
               nxt.step = ST_ERR;
            end
         end
         ST_ERR: begin
            if (item.axis_error_count != '0) begin
               nxt.step = ST_AXERR;
            end else if ((nxt.commands & C_ACK) != '0) begin
               nxt.commands = nxt.commands & ~C_ACK;
               nxt.err      = '0;
               nxt.step     = item.error_stop ? ST_ERST : ST_WAIT;
            end
         end
         ST_AXERR: begin
            if (item.axis_error_valid) begin
               if (item.axis_error_code != '0) begin
                  nxt.err = item.axis_error_code;
               end
               nxt.ack = 1'b0;
               if ((nxt.commands & C_ACK) != '0) begin
                  nxt.commands = nxt.commands & ~C_ACK;
                  if (item.axis_error_code != '0) begin
                     nxt.ack = 1'b1;
                  end
               end
               if (item.axis_error_count == '0) begin
                  nxt.err  = '0;
                  nxt.step = item.error_stop ? ST_ERST : ST_WAIT;
               end
            end
         end
         ST_ERST: begin
            nxt.exe = nxt.exe | E_RESET;
            if (item.unit_error[U_POWER]) begin
               nxt.pwr = 1'b0;
            end
            if (item.unit_done[U_RESET]) begin
               nxt.exe  = nxt.exe & ~E_RESET;
               nxt.step = ST_WAIT;
            end else if (item.unit_error[U_RESET]) begin
               nxt.exe  = nxt.exe & ~E_RESET;
               nxt.step = ST_ERR;
            end
         end
         ST_READ: begin
            nxt.exe = nxt.exe | E_READ;
            if (item.unit_done[U_READ]) begin
               nxt.step = ST_READY;
            end else if (item.unit_error[U_READ]) begin
               nxt.err  = item.active_error_code;
               nxt.exe  = nxt.exe & ~E_READ;
               nxt.step = ST_ERR;
            end
         end
         default: begin
         end
      endcase
   end

endmodule

>>> dv/amcs_tick_checker.sv
// Scoreboard for the motion command sequencer: predicts every tick and checks each response.
`timescale 1ns / 1ps
module amcs_tick_checker
   import amcs_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   amcs_req_if                   req_mon,
   amcs_rsp_if                   rsp_mon,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   input  logic                  csr_pready,
   output int                    mismatches,
   output int                    outstanding
);

   localparam logic [CSR_ADDR_W-1:0] HOME_ON_PU_ADDR = {CSR_IDX_HOME_ON_PU, 2'b00};

   seq_state_type seq;
   logic          home_on_pu;
   rsp_type       expected_rsp[$];
   int            errors_seen = 0;

   // unit fault: record its code, drop its execute latch, park in the error state
   function automatic void enter_error(input logic [EXE_W-1:0] exe_bit,
                                       input logic [CODE_W-1:0] code);
      seq.err  = code;
      seq.exe &= ~exe_bit;
      seq.step = ST_ERR;
   endfunction

   function automatic rsp_type predict_tick(input req_type t);
      logic [CMD_W-1:0] held;
      logic [EXE_W-1:0] eb;
      logic [3:0]       ub;
      logic [4:0]       code;
      rsp_type          o;
      seq.commands = (seq.commands & ~t.cmd_clear) | t.cmd_set;

      // central stop
      if ((seq.commands & C_STOP) != '0 &&
          ((seq.step >= ST_READY && seq.step <= ST_GOUT) || seq.step == ST_AXERR)) begin
         seq.exe      &= ~EXE_STOP_GROUP;
         seq.ack       = 1'b0;
         seq.commands &= ~CMD_STOP_GROUP;
         seq.step      = ST_STOP;
      end

      // axis error and power-off overrides
      if (t.axis_error_code != '0 && t.axis_error_valid)
         seq.step = ST_AXERR;
      else if ((seq.commands & C_POWER) == '0 && t.axis_error_valid)
         seq.step = t.error_stop ? ST_ERST : ST_WAIT;

      case (seq.step)
         ST_WAIT: begin
            if ((seq.commands & C_POWER) != '0)
               seq.step = ST_PON;
            else
               seq.pwr = 1'b0;
            seq.exe      &= ~EXE_STOP_GROUP;
            seq.ack       = 1'b0;
            seq.commands &= ~CMD_STOP_GROUP;
            seq.err       = '0;
         end
         ST_PON: begin
            seq.pwr = 1'b1;
            if (t.unit_done[U_POWER]) begin
               if (home_on_pu)
                  seq.commands |= C_HOME;
               seq.step = ST_READY;
            end
            if (t.unit_error[U_POWER]) begin
               seq.err  = t.active_error_code;
               seq.step = ST_ERR;
            end
         end
         ST_READY: begin
            // fixed priority, one-shot bits consumed on dispatch
            if ((seq.commands & C_HOME) != '0) begin
               seq.commands &= ~C_HOME;
               seq.step      = ST_HOME;
            end else if ((seq.commands & C_STOP) != '0) begin
               seq.step = ST_STOP;
            end else if ((seq.commands & C_JOGP) != '0) begin
               seq.step = ST_JOGP;
            end else if ((seq.commands & C_JOGN) != '0) begin
               seq.step = ST_JOGN;
            end else if ((seq.commands & C_ABS) != '0) begin
               seq.commands &= ~C_ABS;
               seq.step      = ST_ABS;
            end else if ((seq.commands & C_ADD) != '0) begin
               seq.commands &= ~C_ADD;
               seq.step      = ST_ADD;
            end else if ((seq.commands & C_VEL) != '0) begin
               seq.commands &= ~C_VEL;
               seq.step      = ST_VEL;
            end else if ((seq.commands & C_GIN) != '0) begin
               seq.commands &= ~C_GIN;
               seq.step      = ST_GIN;
            end else if ((seq.commands & C_GOUT) != '0) begin
               seq.commands &= ~C_GOUT;
               seq.step      = ST_GOUT;
            end else if ((seq.commands & C_HALT) != '0) begin
               seq.commands &= ~C_HALT;
               seq.step      = ST_HALT;
            end
         end
         ST_HOME: begin
            if (!t.synchronized_motion) begin
               seq.exe |= E_HOME;
               if (t.unit_done[U_HOME]) begin
                  seq.exe &= ~E_HOME;
                  seq.step = ST_READ;
               end
               if (t.unit_error[U_HOME])
                  enter_error(E_HOME, t.active_error_code);
            end else begin
               // geared: ask for a gear-out instead of homing
               seq.step     = ST_READ;
               seq.commands = (seq.commands & ~C_GIN) | C_GOUT;
            end
         end
         ST_HALT: begin
            seq.exe |= E_HALT;
            if (t.unit_done[U_HALT]) begin
               seq.exe &= ~E_HALT;
               seq.step = ST_READY;
            end
            if (t.unit_error[U_HALT])
               enter_error(E_HALT, t.active_error_code);
         end
         ST_STOP: begin
            seq.exe |= E_STOP;
            if (t.unit_done[U_STOP] && (seq.commands & C_STOP) == '0) begin
               seq.exe &= ~E_STOP;
               seq.step = ST_READY;
            end
            if (t.unit_error[U_STOP])
               enter_error(E_STOP, t.active_error_code);
         end
         ST_JOGP, ST_JOGN: begin
            held     = (seq.step == ST_JOGP) ? C_JOGP : C_JOGN;
            seq.vsel = (seq.step == ST_JOGP) ? VSRC_JOGP : VSRC_JOGN;
            seq.exe |= E_VEL;
            if ((seq.commands & held) == '0) begin
               seq.exe &= ~E_VEL;
               seq.step = ST_HALT;
            end
            if (t.unit_error[U_VEL])
               enter_error(E_VEL, t.active_error_code);
         end
         ST_ABS, ST_ADD, ST_VEL: begin
            eb = (seq.step == ST_ABS) ? E_ABS : (seq.step == ST_ADD) ? E_ADD : E_VEL;
            ub = (seq.step == ST_ABS) ? U_ABS : (seq.step == ST_ADD) ? U_ADD : U_VEL;
            if (seq.step == ST_VEL)
               seq.vsel = VSRC_PARAM;
            seq.exe |= eb;
            if ((seq.commands & C_HALT) != '0) begin
               seq.commands &= ~C_HALT;
               seq.exe      &= ~eb;
               seq.step      = ST_HALT;
            end else if (t.unit_done[ub]) begin
               seq.exe &= ~eb;
               seq.step = ST_READY;
            end
            if (t.unit_error[ub])
               enter_error(eb, t.active_error_code);
         end
         ST_GIN, ST_GOUT: begin
            eb = (seq.step == ST_GIN) ? E_GIN : E_GOUT;
            ub = (seq.step == ST_GIN) ? U_GIN : U_GOUT;
            seq.exe |= eb;
            if (t.unit_done[ub]) begin
               seq.exe &= ~eb;
               seq.step = ST_READY;
            end else if (t.unit_error[ub]) begin
               enter_error(eb, t.active_error_code);
            end
         end
         ST_ERR: begin
            if (t.axis_error_count != '0) begin
               seq.step = ST_AXERR;
            end else if ((seq.commands & C_ACK) != '0) begin
               seq.commands &= ~C_ACK;
               seq.err       = '0;
               seq.step      = t.error_stop ? ST_ERST : ST_WAIT;
            end
         end
         ST_AXERR: begin
            if (t.axis_error_valid) begin
               if (t.axis_error_code != '0)
                  seq.err = t.axis_error_code;
               seq.ack = 1'b0;
               if ((seq.commands & C_ACK) != '0) begin
                  seq.commands &= ~C_ACK;
                  if (t.axis_error_code != '0)
                     seq.ack = 1'b1;
               end
               if (t.axis_error_count == '0) begin
                  seq.err  = '0;
                  seq.step = t.error_stop ? ST_ERST : ST_WAIT;
               end
            end
         end
         ST_ERST: begin
            seq.exe |= E_RESET;
            if (t.unit_error[U_POWER])
               seq.pwr = 1'b0;
            if (t.unit_done[U_RESET]) begin
               seq.exe &= ~E_RESET;
               seq.step = ST_WAIT;
            end else if (t.unit_error[U_RESET]) begin
               seq.exe &= ~E_RESET;
               seq.step = ST_ERR;
            end
         end
         ST_READ: begin
            seq.exe |= E_READ;
            if (t.unit_done[U_READ])
               seq.step = ST_READY;
            else if (t.unit_error[U_READ])
               enter_error(E_READ, t.active_error_code);
         end
         default: ;
      endcase

      // read state shows as code 0 in the four-bit field
      code              = seq.step;
      o.step_code       = code[STEP_W-1:0];
      o.unit_execute    = seq.exe;
      o.power_enable    = seq.pwr;
      o.velocity_source = seq.vsel;
      o.axis_error_ack  = seq.ack;
      o.error_code      = seq.err;
      o.command_latch   = seq.commands;
      return o;
   endfunction

   task automatic compare_field(input string field, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
         errors_seen++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      req_type tick;
      if (reset) begin
         seq        = '0;
         seq.step   = ST_WAIT;
         home_on_pu = 1'b0;
         expected_rsp.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr == HOME_ON_PU_ADDR)
            home_on_pu = csr_pwdata[0];

         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_rsp.size() == 0) begin
               $error("response transaction with no tick outstanding");
               errors_seen++;
            end else begin
               want = expected_rsp.pop_front();
               compare_field("step_code", 32'(want.step_code), 32'(rsp_mon.step_code));
               compare_field("unit_execute", 32'(want.unit_execute),
                             32'(rsp_mon.unit_execute));
               compare_field("power_enable", 32'(want.power_enable),
                             32'(rsp_mon.power_enable));
               compare_field("velocity_source", 32'(want.velocity_source),
                             32'(rsp_mon.velocity_source));
               compare_field("axis_error_ack", 32'(want.axis_error_ack),
                             32'(rsp_mon.axis_error_ack));
               compare_field("error_code", 32'(want.error_code), 32'(rsp_mon.error_code));
               compare_field("command_latch", 32'(want.command_latch),
                             32'(rsp_mon.command_latch));
            end
         end

         if (req_mon.valid && req_mon.ready) begin
            tick = {req_mon.cmd_set, req_mon.cmd_clear, req_mon.unit_done,
                    req_mon.unit_error, req_mon.active_error_code, req_mon.axis_error_code,
                    req_mon.axis_error_valid, req_mon.axis_error_count, req_mon.error_stop,
                    req_mon.synchronized_motion};
            expected_rsp.push_back(predict_tick(tick));
         end
      end
      mismatches  <= errors_seen;
      outstanding <= expected_rsp.size();
   end

endmodule

>>> dv/tb_top.sv
// Top of the sequencer testbench: clock, reset, stimulus, flow control and verdict.
`timescale 1ns / 1ps
module tb_top;
   import amcs_pkg::*;

   // home-on-power-up register sits at byte address 4 * index
   localparam logic [CSR_ADDR_W-1:0] HOME_ON_PU_ADDR = {CSR_IDX_HOME_ON_PU, 2'b00};

   // random phases: sender idle and receiver stall, percent of cycles
   localparam int PHASES          = 4;
   localparam int SEND_IDLE[4]    = '{0, 58, 0, 8};
   localparam int RECV_STALL[4]   = '{0, 0, 58, 8};
   localparam int TICKS_PER_PHASE = 488;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;
   int                    fail_count;
   int                    outstanding;
   int                    idle_pct  = 0;
   int                    stall_pct = 0;

   amcs_req_if req_if ();
   amcs_rsp_if rsp_if ();

   axis_motion_command_sequencer_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // watches both channels and the register port, predicts and compares
   amcs_tick_checker CHK (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_if),
      .rsp_mon     (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_pready  (csr_pready),
      .mismatches  (fail_count),
      .outstanding (outstanding)
   );

   always #4 clock = ~clock;

   // receiver back-pressure, redrawn every cycle
   always @(posedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= stall_pct);
   end

   // tick with only the command masks and unit flags set
   function automatic req_type plain_tick(input logic [CMD_W-1:0]  set,
                                          input logic [CMD_W-1:0]  clr,
                                          input logic [UNIT_W-1:0] done,
                                          input logic [UNIT_W-1:0] uerr);
      req_type t;
      t            = '0;
      t.cmd_set    = set;
      t.cmd_clear  = clr;
      t.unit_done  = done;
      t.unit_error = uerr;
      return t;
   endfunction

   // Mostly plausible ticks: sparse commands with power kept on, one done flag at
   // a time, rare unit faults and axis errors. About one in eight is pure noise.
   function automatic req_type random_tick();
      req_type t;
      int      pick;
      t = '0;
      if ($urandom_range(99) < 12) begin
         t.cmd_set             = 12'($urandom);
         t.cmd_clear           = 12'($urandom);
         t.unit_done           = 11'($urandom);
         t.unit_error          = 11'($urandom);
         t.active_error_code   = 16'($urandom);
         t.axis_error_code     = 16'($urandom);
         t.axis_error_valid    = 1'($urandom);
         t.axis_error_count    = 16'($urandom);
         t.error_stop          = 1'($urandom);
         t.synchronized_motion = 1'($urandom);
         return t;
      end
      if ($urandom_range(99) < 35)
         t.cmd_set = C_POWER << $urandom_range(11);
      if ($urandom_range(99) < 15)
         t.cmd_set |= C_POWER;
      // drop anything but power fairly often, power itself rarely
      if ($urandom_range(99) < 25)
         t.cmd_clear = C_STOP << $urandom_range(10);
      else if ($urandom_range(99) < 3)
         t.cmd_clear = C_POWER;
      if ($urandom_range(99) < 45)
         t.unit_done = 11'(1) << $urandom_range(10);
      if ($urandom_range(99) < 5)
         t.unit_error = 11'(1) << $urandom_range(10);
      t.active_error_code = 16'($urandom);
      if ($urandom_range(99) < 30)
         t.axis_error_code = 16'($urandom);
      t.axis_error_valid = ($urandom_range(99) < 12);
      pick = $urandom_range(9);
      if (pick < 5)
         t.axis_error_count = '0;
      else if (pick < 8)
         t.axis_error_count = 16'($urandom_range(3, 1));
      else
         t.axis_error_count = 16'($urandom);
      t.error_stop          = ($urandom_range(99) < 30);
      t.synchronized_motion = ($urandom_range(99) < 15);
      return t;
   endfunction

   // Offers one tick after a random gap and returns once it has been taken.
   // Back-to-back ticks keep valid high: only one assignment per time step.
   task automatic send_tick(input req_type t);
      while ($urandom_range(99) < idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      {req_if.cmd_set, req_if.cmd_clear, req_if.unit_done, req_if.unit_error,
       req_if.active_error_code, req_if.axis_error_code, req_if.axis_error_valid,
       req_if.axis_error_count, req_if.error_stop, req_if.synchronized_motion} <= t;
      do @(posedge clock); while (!req_if.ready);
   endtask

   // Stop offering, wait for every response, then cover the input and response registers.
   // The counter is registered, hence the first wait before it is looked at.
   task automatic settle();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (4) @(posedge clock);
   endtask

   // setup cycle, then access cycle; the write lands when pready is seen
   task automatic write_home_on_pu(input logic value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= HOME_ON_PU_ADDR;
      csr_pwdata  <= {{(CSR_DATA_W-1){1'b0}}, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   initial begin
      req_type script[$];
      req_type t;
      req_if.valid = 1'b0;
      {req_if.cmd_set, req_if.cmd_clear, req_if.unit_done, req_if.unit_error,
       req_if.active_error_code, req_if.axis_error_code, req_if.axis_error_valid,
       req_if.axis_error_count, req_if.error_stop, req_if.synchronized_motion} = '0;
      csr_psel     = 1'b0;
      csr_penable  = 1'b0;
      csr_pwrite   = 1'b0;
      csr_paddr    = '0;
      csr_pwdata   = '0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // homing requested automatically after power-on for the directed walk
      write_home_on_pu(1'b1);

      // Directed walk: power-on into automatic homing and the read step, jog and
      // release into halt, a move broken off by halt, the central stop, a gear
      // fault, the axis error path with acknowledge, the error-stop reset, then
      // all-ones and clear-everything ticks.
      script.push_back(plain_tick('0, '0, '0, '0));
      script.push_back(plain_tick(C_POWER, '0, '0, '0));
      script.push_back(plain_tick('0, '0, 11'(1) << U_POWER, '0));
      script.push_back(plain_tick('0, '0, '0, '0));
      script.push_back(plain_tick('0, '0, '0, '0));
      script.push_back(plain_tick('0, '0, 11'(1) << U_HOME, '0));
      script.push_back(plain_tick('0, '0, 11'(1) << U_READ, '0));
      script.push_back(plain_tick(C_JOGP, '0, '0, '0));
      script.push_back(plain_tick('0, '0, '0, '0));
      script.push_back(plain_tick('0, C_JOGP, '0, '0));
      script.push_back(plain_tick('0, '0, 11'(1) << U_HALT, '0));
      script.push_back(plain_tick(C_ABS, '0, '0, '0));
      script.push_back(plain_tick(C_HALT, '0, '0, '0));
      script.push_back(plain_tick('0, '0, 11'(1) << U_HALT, '0));
      script.push_back(plain_tick(C_STOP, '0, '0, '0));
      script.push_back(plain_tick('0, '0, 11'(1) << U_STOP, '0));
      script.push_back(plain_tick(C_GIN, '0, '0, '0));
      t = plain_tick('0, '0, '0, 11'(1) << U_GIN);
      t.active_error_code = 16'hBEEF;
      script.push_back(t);
      t = plain_tick('0, '0, '0, '0);
      t.axis_error_count = 16'd2;
      script.push_back(t);
      t = plain_tick(C_ACK, '0, '0, '0);
      t.axis_error_valid = 1'b1;
      t.axis_error_code  = 16'h1234;
      t.axis_error_count = 16'd1;
      script.push_back(t);
      t = plain_tick('0, '0, '0, '0);
      t.axis_error_valid = 1'b1;
      t.error_stop       = 1'b1;
      script.push_back(t);
      script.push_back(plain_tick('0, '0, 11'(1) << U_RESET, '0));
      script.push_back('1);
      script.push_back(plain_tick('0, '1, '0, '0));
      foreach (script[i])
         send_tick(script[i]);

      // random phases; the register is rewritten only once the pipe is empty
      for (int ph = 0; ph < PHASES; ph++) begin
         settle();
         write_home_on_pu(ph[0]);
         idle_pct  = SEND_IDLE[ph];
         stall_pct = RECV_STALL[ph];
         for (int i = 0; i < TICKS_PER_PHASE; i++) begin
            // let the pipe run dry once mid-stream
            if (ph == 1 && i == TICKS_PER_PHASE / 2)
               settle();
            send_tick(random_tick());
         end
      end
      settle();

      if (fail_count == 0) begin
         $display("axis_motion_command_sequencer_unit test passed");
      end else begin
         $display("axis_motion_command_sequencer_unit test failed");
      end
      $finish;
   end

   // hang guard, far beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("axis_motion_command_sequencer_unit test failed");
      $finish;
   end

endmodule
